// File: hdl/csma_pkg.sv
// ----------------------------------------------------------------------------
// csma_pkg
// Shared types, codes and reset constants of the CSMA/CA MAC controller.
// ----------------------------------------------------------------------------
package csma_pkg;

  // Field widths
  localparam int unsigned TickW  = 16;
  localparam int unsigned CwW    = 10;
  localparam int unsigned RetryW = 4;
  localparam int unsigned RndW   = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Fixed contention window for group-addressed frames
  localparam logic [CwW-1:0] CW_MULTICAST = 10'd31;

  // Configuration reset values
  localparam logic              RST_USE_ACK     = 1'b1;
  localparam logic [TickW-1:0]  RST_SLOT_TICKS  = 16'd20;
  localparam logic [TickW-1:0]  RST_SIFS_TICKS  = 16'd10;
  localparam logic [TickW-1:0]  RST_DIFS_TICKS  = 16'd50;
  localparam logic [TickW-1:0]  RST_ACK_TICKS   = 16'd300;
  localparam logic [CwW-1:0]    RST_CW_MIN      = 10'd31;
  localparam logic [CwW-1:0]    RST_CW_MAX      = 10'd1023;
  localparam logic [RetryW-1:0] RST_RETRY_LIMIT = 4'd7;

  // Input item kinds
  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_OFFER   = 3'd1,
    KIND_MEDIUM  = 3'd2,
    KIND_TX_DONE = 3'd3,
    KIND_RX      = 3'd4
  } kind_e;

  // Medium state codes (code three counts as busy)
  typedef enum logic [1:0] {
    MED_IDLE      = 2'd0,
    MED_BUSY      = 2'd1,
    MED_RECEIVING = 2'd2,
    MED_BUSY_ALT  = 2'd3
  } medium_e;

  // Result action codes
  typedef enum logic [2:0] {
    ACT_NONE          = 3'd0,
    ACT_SEND_DATA     = 3'd1,
    ACT_SEND_ACK      = 3'd2,
    ACT_DELIVER       = 3'd3,
    ACT_DROP_BAD      = 3'd4,
    ACT_DROP_NOT_OURS = 3'd5,
    ACT_SENT          = 3'd6,
    ACT_GIVEN_UP      = 3'd7
  } action_e;

  // Reported MAC state codes
  typedef enum logic [2:0] {
    MS_IDLE     = 3'd0,
    MS_DEFER    = 3'd1,
    MS_WAITDIFS = 3'd2,
    MS_BACKOFF  = 3'd3,
    MS_TRANSMIT = 3'd4,
    MS_WAITACK  = 3'd5,
    MS_RECEIVE  = 3'd6,
    MS_WAITSIFS = 3'd7
  } mac_state_e;

  // Control phase, one-hot
  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_DEFER    = 8'b0000_0010,
    PH_WAITDIFS = 8'b0000_0100,
    PH_BACKOFF  = 8'b0000_1000,
    PH_TRANSMIT = 8'b0001_0000,
    PH_WAITACK  = 8'b0010_0000,
    PH_RECEIVE  = 8'b0100_0000,
    PH_WAITSIFS = 8'b1000_0000
  } phase_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_USE_ACK     = 3'd0,
    REG_SLOT_TICKS  = 3'd1,
    REG_SIFS_TICKS  = 3'd2,
    REG_DIFS_TICKS  = 3'd3,
    REG_ACK_TICKS   = 3'd4,
    REG_CW_MIN      = 3'd5,
    REG_CW_MAX      = 3'd6,
    REG_RETRY_LIMIT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]      kind;
    logic [1:0]      medium_state;
    logic [1:0]      dest_group;
    logic [RndW-1:0] random_value;
    logic            rx_fcs_ok;
    logic            rx_is_ack;
    logic            rx_broadcast;
    logic            rx_for_us;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [2:0]        mac_state;
    logic              ready_for_frame;
    logic              frame_rejected;
    logic [RetryW-1:0] retries_used;
  } res_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic              use_ack;
    logic [TickW-1:0]  slot_ticks;
    logic [TickW-1:0]  sifs_ticks;
    logic [TickW-1:0]  difs_ticks;
    logic [TickW-1:0]  ack_timeout_ticks;
    logic [CwW-1:0]    cw_min;
    logic [CwW-1:0]    cw_max;
    logic [RetryW-1:0] retry_limit;
  } cfg_t;

  // One-hot phase to reported state code
  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] code;
    case (ph)
      PH_IDLE:     code = MS_IDLE;
      PH_DEFER:    code = MS_DEFER;
      PH_WAITDIFS: code = MS_WAITDIFS;
      PH_BACKOFF:  code = MS_BACKOFF;
      PH_TRANSMIT: code = MS_TRANSMIT;
      PH_WAITACK:  code = MS_WAITACK;
      PH_RECEIVE:  code = MS_RECEIVE;
      PH_WAITSIFS: code = MS_WAITSIFS;
      default:     code = MS_IDLE;
    endcase
    return code;
  endfunction

endpackage

// File: hdl/csma_stream_if.sv
// ----------------------------------------------------------------------------
// csma_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface csma_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/csma_cfg.sv
// ----------------------------------------------------------------------------
// csma_cfg
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module csma_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  csma_stream_if.sink          cfg_i,
  output csma_pkg::cfg_t       cfg_o
);

  csma_pkg::cfg_t cfg_q;

  // Writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_ack           <= csma_pkg::RST_USE_ACK;
      cfg_q.slot_ticks        <= csma_pkg::RST_SLOT_TICKS;
      cfg_q.sifs_ticks        <= csma_pkg::RST_SIFS_TICKS;
      cfg_q.difs_ticks        <= csma_pkg::RST_DIFS_TICKS;
      cfg_q.ack_timeout_ticks <= csma_pkg::RST_ACK_TICKS;
      cfg_q.cw_min            <= csma_pkg::RST_CW_MIN;
      cfg_q.cw_max            <= csma_pkg::RST_CW_MAX;
      cfg_q.retry_limit       <= csma_pkg::RST_RETRY_LIMIT;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        csma_pkg::REG_USE_ACK:     cfg_q.use_ack           <= cfg_i.payload.data[0];
        csma_pkg::REG_SLOT_TICKS:  cfg_q.slot_ticks        <= cfg_i.payload.data[15:0];
        csma_pkg::REG_SIFS_TICKS:  cfg_q.sifs_ticks        <= cfg_i.payload.data[15:0];
        csma_pkg::REG_DIFS_TICKS:  cfg_q.difs_ticks        <= cfg_i.payload.data[15:0];
        csma_pkg::REG_ACK_TICKS:   cfg_q.ack_timeout_ticks <= cfg_i.payload.data[15:0];
        csma_pkg::REG_CW_MIN:      cfg_q.cw_min            <= cfg_i.payload.data[9:0];
        csma_pkg::REG_CW_MAX:      cfg_q.cw_max            <= cfg_i.payload.data[9:0];
        csma_pkg::REG_RETRY_LIMIT: cfg_q.retry_limit       <= cfg_i.payload.data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/csma_slot_draw.sv
// ----------------------------------------------------------------------------
// csma_slot_draw
// Contention window selection and backoff slot draw: (rnd * (cw + 1)) >> 10.
// ----------------------------------------------------------------------------
module csma_slot_draw (
  input  logic [1:0]                  group_i,
  input  logic [csma_pkg::RetryW-1:0] retry_i,
  input  logic [csma_pkg::CwW-1:0]    cw_min_i,
  input  logic [csma_pkg::CwW-1:0]    cw_max_i,
  input  logic [csma_pkg::RndW-1:0]   rnd_i,
  output logic [csma_pkg::CwW-1:0]    slots_o
);

  // (cw_min + 1) << 15 needs 26 bits
  localparam int unsigned ExpW = csma_pkg::CwW + 16;

  logic [ExpW-1:0]             cw_base;
  logic [ExpW-1:0]             cw_exp;
  logic [csma_pkg::CwW-1:0]    cw;
  logic [csma_pkg::CwW:0]      cw_p1;
  logic [csma_pkg::RndW+csma_pkg::CwW:0] prod;

  // Binary exponential window, capped; fixed window for group frames
  always_comb begin
    cw_base = ExpW'(cw_min_i) + ExpW'(1);
    cw_exp  = (cw_base << retry_i) - ExpW'(1);
    if (group_i != 2'd0) begin
      cw = csma_pkg::CW_MULTICAST;
    end else if (cw_exp > ExpW'(cw_max_i)) begin
      cw = cw_max_i;
    end else begin
      cw = cw_exp[csma_pkg::CwW-1:0];
    end
  end

  assign cw_p1   = {1'b0, cw} + 11'd1;
  assign prod    = {1'b0, rnd_i} * cw_p1;
  assign slots_o = prod[csma_pkg::RndW+csma_pkg::CwW-1:csma_pkg::RndW];

endmodule

// File: hdl/csma_core.sv
// ----------------------------------------------------------------------------
// csma_core
// MAC control state and the single-pass step logic for one item.
// ----------------------------------------------------------------------------
module csma_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  csma_pkg::in_item_t      item_i,
  input  csma_pkg::cfg_t          cfg_i,
  output csma_pkg::res_item_t     res_o
);

  // State registers
  csma_pkg::phase_e               phase_q, phase_d;
  logic                           pend_q, pend_d;
  logic [1:0]                     grp_q, grp_d;
  logic [1:0]                     med_q, med_d;
  logic [csma_pkg::RetryW-1:0]    retry_q, retry_d;
  logic                           bval_q, bval_d;
  logic [csma_pkg::CwW-1:0]       slots_q, slots_d;
  logic [csma_pkg::TickW-1:0]     timer_q, timer_d;
  logic [csma_pkg::TickW-1:0]     stc_q, stc_d;

  // Values after the event itself, before idle resolution and entry
  csma_pkg::phase_e               ev_phase;
  logic                           ev_pend;
  logic [1:0]                     ev_grp;
  logic [1:0]                     ev_med;
  logic [csma_pkg::RetryW-1:0]    ev_retry;
  logic                           ev_bval;
  logic [csma_pkg::CwW-1:0]       ev_slots;
  logic [csma_pkg::TickW-1:0]     ev_timer;
  logic [csma_pkg::TickW-1:0]     ev_stc;
  logic                           ev_enter;
  csma_pkg::phase_e               ev_tgt;
  logic                           ev_draw;
  logic [2:0]                     ev_act;
  logic                           ev_rej;

  logic [csma_pkg::TickW-1:0]     tdec;
  logic                           texp;
  logic [csma_pkg::TickW-1:0]     stc_inc;
  logic [csma_pkg::CwW-1:0]       slots_dec;
  logic                           free_m;
  logic                           rx_m;
  csma_pkg::phase_e               access_tgt;
  logic [csma_pkg::CwW-1:0]       drawn;

  logic                           enter;
  csma_pkg::phase_e               tgt;
  logic [2:0]                     act;

  // Timer saturates at zero and expires on the tick that reads zero
  assign tdec      = (timer_q != '0) ? timer_q - 16'd1 : '0;
  assign texp      = (tdec == '0);
  assign stc_inc   = stc_q + 16'd1;
  assign slots_dec = slots_q - 10'd1;
  assign free_m    = (item_i.medium_state == csma_pkg::MED_IDLE);
  assign rx_m      = (item_i.medium_state == csma_pkg::MED_RECEIVING);

  // Phase of a fresh access attempt given the medium after the event
  assign access_tgt = (ev_med != csma_pkg::MED_IDLE) ? csma_pkg::PH_DEFER :
                      cfg_i.use_ack ? csma_pkg::PH_WAITDIFS : csma_pkg::PH_BACKOFF;

  // Event handling
  always_comb begin
    ev_phase = phase_q;
    ev_pend  = pend_q;
    ev_grp   = grp_q;
    ev_med   = med_q;
    ev_retry = retry_q;
    ev_bval  = bval_q;
    ev_slots = slots_q;
    ev_timer = timer_q;
    ev_stc   = stc_q;
    ev_enter = 1'b0;
    ev_tgt   = csma_pkg::PH_IDLE;
    ev_draw  = 1'b0;
    ev_act   = csma_pkg::ACT_NONE;
    ev_rej   = 1'b0;

    case (item_i.kind)
      csma_pkg::KIND_TICK: begin
        case (phase_q)
          csma_pkg::PH_WAITDIFS: begin
            ev_timer = tdec;
            if (texp) begin
              ev_enter = 1'b1;
              ev_tgt   = csma_pkg::PH_BACKOFF;
            end
          end
          csma_pkg::PH_BACKOFF: begin
            if (slots_q == '0) begin
              ev_enter = 1'b1;
              ev_tgt   = csma_pkg::PH_TRANSMIT;
            end else if (stc_inc >= cfg_i.slot_ticks) begin
              ev_stc   = '0;
              ev_slots = slots_dec;
              if (slots_dec == '0) begin
                ev_enter = 1'b1;
                ev_tgt   = csma_pkg::PH_TRANSMIT;
              end
            end else begin
              ev_stc = stc_inc;
            end
          end
          csma_pkg::PH_WAITACK: begin
            ev_timer = tdec;
            if (texp) begin
              if (retry_q >= cfg_i.retry_limit) begin
                ev_pend  = 1'b0;
                ev_bval  = 1'b0;
                ev_retry = '0;
                ev_act   = csma_pkg::ACT_GIVEN_UP;
              end else begin
                ev_retry = retry_q + 4'd1;
                ev_draw  = 1'b1;
              end
              ev_phase = csma_pkg::PH_IDLE;
            end
          end
          csma_pkg::PH_WAITSIFS: begin
            ev_timer = tdec;
            if (texp) begin
              ev_act   = csma_pkg::ACT_SEND_ACK;
              ev_phase = csma_pkg::PH_IDLE;
            end
          end
          default: ;
        endcase
      end

      // Access for an offer in idle starts through idle resolution
      csma_pkg::KIND_OFFER: begin
        if (pend_q) begin
          ev_rej = 1'b1;
        end else begin
          ev_pend  = 1'b1;
          ev_grp   = item_i.dest_group;
          ev_bval  = 1'b0;
          ev_retry = '0;
        end
      end

      csma_pkg::KIND_MEDIUM: begin
        ev_med = item_i.medium_state;
        case (phase_q)
          csma_pkg::PH_DEFER: begin
            if (free_m) begin
              ev_enter = 1'b1;
              ev_tgt   = cfg_i.use_ack ? csma_pkg::PH_WAITDIFS : csma_pkg::PH_BACKOFF;
            end else if (rx_m) begin
              ev_enter = 1'b1;
              ev_tgt   = csma_pkg::PH_RECEIVE;
            end
          end
          csma_pkg::PH_WAITDIFS,
          csma_pkg::PH_BACKOFF: begin
            if (rx_m) begin
              ev_enter = 1'b1;
              ev_tgt   = csma_pkg::PH_RECEIVE;
            end else if (!free_m) begin
              ev_enter = 1'b1;
              ev_tgt   = csma_pkg::PH_DEFER;
            end
          end
          default: ;
        endcase
      end

      csma_pkg::KIND_TX_DONE: begin
        if (phase_q == csma_pkg::PH_TRANSMIT) begin
          if (grp_q != 2'd0 || !cfg_i.use_ack) begin
            ev_pend  = 1'b0;
            ev_bval  = 1'b0;
            ev_retry = '0;
            ev_act   = csma_pkg::ACT_SENT;
            ev_phase = csma_pkg::PH_IDLE;
          end else begin
            ev_enter = 1'b1;
            ev_tgt   = csma_pkg::PH_WAITACK;
          end
        end
      end

      csma_pkg::KIND_RX: begin
        if (phase_q == csma_pkg::PH_WAITACK) begin
          if (item_i.rx_fcs_ok && item_i.rx_for_us && item_i.rx_is_ack) begin
            ev_pend  = 1'b0;
            ev_bval  = 1'b0;
            ev_retry = '0;
            ev_act   = csma_pkg::ACT_SENT;
            ev_phase = csma_pkg::PH_IDLE;
          end
        end else if (phase_q == csma_pkg::PH_RECEIVE) begin
          ev_phase = csma_pkg::PH_IDLE;
          if (!item_i.rx_fcs_ok) begin
            ev_act = csma_pkg::ACT_DROP_BAD;
          end else if (item_i.rx_is_ack) begin
            ev_act = csma_pkg::ACT_NONE;
          end else if (item_i.rx_broadcast) begin
            ev_act = csma_pkg::ACT_DELIVER;
          end else if (item_i.rx_for_us) begin
            ev_act = csma_pkg::ACT_DELIVER;
            if (cfg_i.use_ack) begin
              ev_enter = 1'b1;
              ev_tgt   = csma_pkg::PH_WAITSIFS;
            end
          end else begin
            ev_act = csma_pkg::ACT_DROP_NOT_OURS;
          end
        end
      end

      default: ;
    endcase
  end

  // One slot draw per item, from the group and retry count after the event
  csma_slot_draw u_draw (
    .group_i  (ev_grp),
    .retry_i  (ev_retry),
    .cw_min_i (cfg_i.cw_min),
    .cw_max_i (cfg_i.cw_max),
    .rnd_i    (item_i.random_value),
    .slots_o  (drawn)
  );

  // Idle resolution and phase entry effects
  always_comb begin
    pend_d  = ev_pend;
    grp_d   = ev_grp;
    med_d   = ev_med;
    retry_d = ev_retry;
    bval_d  = ev_bval;
    slots_d = ev_slots;
    timer_d = ev_timer;
    stc_d   = ev_stc;
    act     = ev_act;
    enter   = ev_enter;
    tgt     = ev_tgt;

    if (ev_draw) begin
      slots_d = drawn;
      bval_d  = 1'b1;
    end

    if (!ev_enter && ev_phase == csma_pkg::PH_IDLE) begin
      if (ev_med == csma_pkg::MED_RECEIVING) begin
        enter = 1'b1;
        tgt   = csma_pkg::PH_RECEIVE;
      end else if (ev_pend) begin
        enter = 1'b1;
        tgt   = access_tgt;
      end
    end

    phase_d = enter ? tgt : ev_phase;

    if (enter) begin
      case (tgt)
        csma_pkg::PH_WAITDIFS: timer_d = cfg_i.difs_ticks;
        csma_pkg::PH_BACKOFF: begin
          if (!bval_d) begin
            slots_d = drawn;
            bval_d  = 1'b1;
          end
          stc_d = '0;
        end
        csma_pkg::PH_TRANSMIT: begin
          bval_d = 1'b0;
          act    = csma_pkg::ACT_SEND_DATA;
        end
        csma_pkg::PH_WAITACK:  timer_d = cfg_i.ack_timeout_ticks;
        csma_pkg::PH_WAITSIFS: timer_d = cfg_i.sifs_ticks;
        default: ;
      endcase
    end
  end

  // Result of this item, from the state it leaves behind
  assign res_o.action          = act;
  assign res_o.mac_state       = csma_pkg::phase_code(phase_d);
  assign res_o.ready_for_frame = (phase_d == csma_pkg::PH_IDLE) && !pend_d;
  assign res_o.frame_rejected  = ev_rej;
  assign res_o.retries_used    = retry_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= csma_pkg::PH_IDLE;
      pend_q  <= 1'b0;
      grp_q   <= '0;
      med_q   <= csma_pkg::MED_IDLE;
      retry_q <= '0;
      bval_q  <= 1'b0;
      slots_q <= '0;
      timer_q <= '0;
      stc_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      grp_q   <= grp_d;
      med_q   <= med_d;
      retry_q <= retry_d;
      bval_q  <= bval_d;
      slots_q <= slots_d;
      timer_q <= timer_d;
      stc_q   <= stc_d;
    end
  end

endmodule

// File: hdl/csma_ca_mac_controller.sv
// ----------------------------------------------------------------------------
// csma_ca_mac_controller
// CSMA/CA MAC control machine with binary exponential backoff.
// ----------------------------------------------------------------------------
// Each input item (tick, frame offer, medium change, end of transmission or
// received frame) gives exactly one result item: action code, MAC state after
// the item, ready-for-frame, offer-rejected flag and retry count. Items are
// taken one per clock unless the result stalls: an input register feeds
// one pass of the state machine, slot draw multiplier and counters, and the
// result lands in an output register; the MAC state updates at that same
// edge, so the next item sees it at once. A stalled result holds the
// pipeline without losing items. Configuration writes are taken every cycle
// and must be issued only while no item is in flight.
// ----------------------------------------------------------------------------
module csma_ca_mac_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  csma_stream_if.sink   in_i,
  csma_stream_if.source res_o,
  csma_stream_if.sink   cfg_i
);

  csma_pkg::cfg_t      cfg;
  logic                in_vld_q;
  csma_pkg::in_item_t  in_item_q;
  logic                out_vld_q;
  csma_pkg::res_item_t out_item_q;
  csma_pkg::res_item_t step_res;
  logic                adv;

  csma_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Pipeline moves when the result register is empty or being drained
  assign adv        = !out_vld_q || res_o.ready;
  assign in_i.ready = !in_vld_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= in_i.payload;
    end
  end

  csma_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_vld_q && adv),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q && adv) begin
      out_item_q <= step_res;
    end
  end

  assign res_o.valid   = out_vld_q;
  assign res_o.payload = out_item_q;

`ifndef SYNTHESIS
  // An item waiting in the input register is never dropped by a stall
  a_in_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> in_vld_q)
    else $error("input item lost while result stalled");

  // A rejected offer leaves the pending frame in place
  a_reject : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_item_q.frame_rejected) |->
      (out_item_q.action == csma_pkg::ACT_NONE && !out_item_q.ready_for_frame))
    else $error("rejected offer changed action or readiness");

  // Data is sent only on entry to transmit
  a_send_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_item_q.action == csma_pkg::ACT_SEND_DATA) |->
      (out_item_q.mac_state == csma_pkg::MS_TRANSMIT))
    else $error("send data outside transmit");
`endif

endmodule

// File: tb/sv/csma_ca_mac_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csma_ca_mac_controller_tb
// Self-checking bench for the CSMA/CA MAC controller. A state-aware generator
// drives ticks, offers, medium changes, end-of-transmission and received
// frames through a series of register settings; a tracker class follows the
// DCF machine and checks every result item field by field.
// ----------------------------------------------------------------------------
module csma_ca_mac_controller_tb;
  import csma_pkg::*;

  localparam int unsigned ITEM_TARGET = 1950;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 400;

  // Codes without a package enum
  localparam logic [2:0] KIND_RESERVED      = 3'd7;
  localparam logic [1:0] DEST_UNICAST       = 2'd0;
  localparam logic [1:0] DEST_MULTICAST     = 2'd1;
  localparam logic [1:0] DEST_BROADCAST     = 2'd2;
  localparam logic [1:0] DEST_BROADCAST_ALT = 2'd3;
  // Received-frame flags, ordered {fcs_ok, is_ack, broadcast, for_us}
  localparam logic [3:0] RX_NONE  = 4'b0000;
  localparam logic [3:0] RX_OK    = 4'b1000;
  localparam logic [3:0] RX_ACK   = 4'b0100;
  localparam logic [3:0] RX_BCAST = 4'b0010;
  localparam logic [3:0] RX_US    = 4'b0001;
  localparam logic [3:0] RX_ALL   = 4'b1111;

  // Tracks the DCF machine and holds the result items still due
  class dcf_tracker;
    cfg_t        cfg;
    mac_state_e  state;
    bit          frame_held;
    logic [1:0]  frame_group;
    logic [1:0]  med_now;
    logic [3:0]  retries;
    bit          slots_drawn;
    logic [9:0]  slots_left;
    logic [15:0] timer;
    int unsigned slot_phase;
    action_e     act;
    res_item_t   due_results[$];
    int unsigned errors;

    function new();
      cfg = '{RST_USE_ACK, RST_SLOT_TICKS, RST_SIFS_TICKS, RST_DIFS_TICKS,
              RST_ACK_TICKS, RST_CW_MIN, RST_CW_MAX, RST_RETRY_LIMIT};
      state       = MS_IDLE;
      frame_held  = 1'b0;
      frame_group = DEST_UNICAST;
      med_now     = MED_IDLE;
      retries     = '0;
      slots_drawn = 1'b0;
      slots_left  = '0;
      timer       = '0;
      slot_phase  = 0;
      errors      = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] data);
      case (idx)
        REG_USE_ACK:     cfg.use_ack           = data[0];
        REG_SLOT_TICKS:  cfg.slot_ticks        = data;
        REG_SIFS_TICKS:  cfg.sifs_ticks        = data;
        REG_DIFS_TICKS:  cfg.difs_ticks        = data;
        REG_ACK_TICKS:   cfg.ack_timeout_ticks = data;
        REG_CW_MIN:      cfg.cw_min            = data[9:0];
        REG_CW_MAX:      cfg.cw_max            = data[9:0];
        REG_RETRY_LIMIT: cfg.retry_limit       = data[3:0];
        default: ;
      endcase
    endfunction

    // Backoff draw: group frames use the fixed window
    function void pick_slots(logic [9:0] rnd);
      int unsigned cw;
      if (frame_group != DEST_UNICAST) begin
        cw = CW_MULTICAST;
      end else begin
        cw = 32'(cfg.cw_min) + 1;
        cw = (cw << retries) - 1;
        if (cw > cfg.cw_max) cw = cfg.cw_max;
      end
      slots_left  = 10'((32'(rnd) * (cw + 1)) >> 10);
      slots_drawn = 1'b1;
    endfunction

    function void go_to(mac_state_e nxt, logic [9:0] rnd);
      state = nxt;
      case (nxt)
        MS_WAITDIFS: timer = cfg.difs_ticks;
        MS_BACKOFF: begin
          if (!slots_drawn) pick_slots(rnd);
          slot_phase = 0;
        end
        MS_TRANSMIT: begin
          slots_drawn = 1'b0;
          act = ACT_SEND_DATA;
        end
        MS_WAITACK:  timer = cfg.ack_timeout_ticks;
        MS_WAITSIFS: timer = cfg.sifs_ticks;
        default: ;
      endcase
    endfunction

    function mac_state_e access_phase();
      if (cfg.use_ack) return MS_WAITDIFS;
      return MS_BACKOFF;
    endfunction

    function void begin_access(logic [9:0] rnd);
      if (med_now == MED_IDLE) go_to(access_phase(), rnd);
      else go_to(MS_DEFER, rnd);
    endfunction

    function void retire_frame();
      frame_held  = 1'b0;
      slots_drawn = 1'b0;
      retries     = '0;
    endfunction

    // Saturating countdown; fires on the tick that reads zero
    function bit timer_done();
      if (timer != 0) timer--;
      return timer == 0;
    endfunction

    function void handle_tick(logic [9:0] rnd);
      case (state)
        MS_WAITDIFS: if (timer_done()) go_to(MS_BACKOFF, rnd);
        MS_BACKOFF: begin
          if (slots_left == 0) begin
            go_to(MS_TRANSMIT, rnd);
          end else begin
            slot_phase++;
            if (slot_phase >= cfg.slot_ticks) begin
              slot_phase = 0;
              slots_left--;
              if (slots_left == 0) go_to(MS_TRANSMIT, rnd);
            end
          end
        end
        MS_WAITACK: begin
          if (timer_done()) begin
            if (retries >= cfg.retry_limit) begin
              retire_frame();
              act = ACT_GIVEN_UP;
            end else begin
              retries++;
              pick_slots(rnd);
            end
            state = MS_IDLE;
          end
        end
        MS_WAITSIFS: begin
          if (timer_done()) begin
            act   = ACT_SEND_ACK;
            state = MS_IDLE;
          end
        end
        default: ;
      endcase
    endfunction

    function void handle_medium(logic [9:0] rnd);
      bit free_now;
      bit rx_now;
      free_now = (med_now == MED_IDLE);
      rx_now   = (med_now == MED_RECEIVING);
      case (state)
        MS_IDLE: if (rx_now) go_to(MS_RECEIVE, rnd);
        MS_DEFER: begin
          if (free_now) go_to(access_phase(), rnd);
          else if (rx_now) go_to(MS_RECEIVE, rnd);
        end
        MS_WAITDIFS, MS_BACKOFF: begin
          if (rx_now) go_to(MS_RECEIVE, rnd);
          else if (!free_now) go_to(MS_DEFER, rnd);
        end
        default: ;
      endcase
    endfunction

    function void handle_rx(in_item_t it);
      if (state == MS_WAITACK) begin
        if (it.rx_fcs_ok && it.rx_for_us && it.rx_is_ack) begin
          retire_frame();
          act   = ACT_SENT;
          state = MS_IDLE;
        end
      end else if (state == MS_RECEIVE) begin
        state = MS_IDLE;
        if (!it.rx_fcs_ok) act = ACT_DROP_BAD;
        else if (it.rx_is_ack) act = ACT_NONE;
        else if (it.rx_broadcast) act = ACT_DELIVER;
        else if (it.rx_for_us) begin
          act = ACT_DELIVER;
          if (cfg.use_ack) go_to(MS_WAITSIFS, '0);
        end else act = ACT_DROP_NOT_OURS;
      end
    endfunction

    function res_item_t predict_result(in_item_t it);
      res_item_t res;
      bit        rejected;
      act      = ACT_NONE;
      rejected = 1'b0;
      case (it.kind)
        KIND_TICK: handle_tick(it.random_value);
        KIND_OFFER: begin
          if (frame_held) begin
            rejected = 1'b1;
          end else begin
            frame_held  = 1'b1;
            frame_group = it.dest_group;
            slots_drawn = 1'b0;
            retries     = '0;
            if (state == MS_IDLE) begin_access(it.random_value);
          end
        end
        KIND_MEDIUM: begin
          med_now = it.medium_state;
          handle_medium(it.random_value);
        end
        KIND_TX_DONE: begin
          if (state == MS_TRANSMIT) begin
            if (frame_group != DEST_UNICAST || !cfg.use_ack) begin
              retire_frame();
              act   = ACT_SENT;
              state = MS_IDLE;
            end else begin
              go_to(MS_WAITACK, it.random_value);
            end
          end
        end
        KIND_RX: handle_rx(it);
        default: ;
      endcase
      // Idle never persists while the medium receives or a frame waits
      if (state == MS_IDLE) begin
        if (med_now == MED_RECEIVING) go_to(MS_RECEIVE, it.random_value);
        else if (frame_held) begin_access(it.random_value);
      end
      res.action          = act;
      res.mac_state       = state;
      res.ready_for_frame = (state == MS_IDLE) && !frame_held;
      res.frame_rejected  = rejected;
      res.retries_used    = retries;
      return res;
    endfunction

    function void note_item(in_item_t it);
      due_results.push_back(predict_result(it));
    endfunction

    function void compare_field(string name, logic [3:0] want_v, logic [3:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0d, got %0d", name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      if (due_results.size() == 0) begin
        $error("result item with none due: action %0d state %0d", got.action, got.mac_state);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("action", want.action, got.action);
      compare_field("mac_state", want.mac_state, got.mac_state);
      compare_field("ready_for_frame", want.ready_for_frame, got.ready_for_frame);
      compare_field("frame_rejected", want.frame_rejected, got.frame_rejected);
      compare_field("retries_used", want.retries_used, got.retries_used);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  csma_stream_if #(.payload_t(in_item_t))  in_if ();
  csma_stream_if #(.payload_t(res_item_t)) res_if ();
  csma_stream_if #(.payload_t(cfg_wr_t))   cfg_if ();

  csma_ca_mac_controller uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  dcf_tracker  sb = new();
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  // Result side: random stalls, plus one long hold on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Check each accepted result item
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) sb.check_result(res_if.payload);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Write all eight registers; unused upper data bits carry junk
  task automatic write_config(cfg_t c);
    logic [15:0] junk;
    logic [15:0] data;
    cfg_idx_e    idx;
    for (int i = 0; i < 8; i++) begin
      idx  = cfg_idx_e'(i);
      junk = 16'($urandom);
      case (idx)
        REG_USE_ACK:     data = {junk[15:1], c.use_ack};
        REG_SLOT_TICKS:  data = c.slot_ticks;
        REG_SIFS_TICKS:  data = c.sifs_ticks;
        REG_DIFS_TICKS:  data = c.difs_ticks;
        REG_ACK_TICKS:   data = c.ack_timeout_ticks;
        REG_CW_MIN:      data = {junk[15:10], c.cw_min};
        REG_CW_MAX:      data = {junk[15:10], c.cw_max};
        default:         data = {junk[15:4], c.retry_limit};
      endcase
      cfg_if.valid   <= 1'b1;
      cfg_if.payload <= {idx, data};
      do @(posedge clk_i); while (!cfg_if.ready);
      sb.write_reg(idx, data);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Offer one item, in bursts with random gaps between them
  task automatic send_item(in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      if (gaps_on) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(10, 1)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(it);
    items_sent++;
  endtask

  // Stop offering and wait for every result item still due
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic in_item_t mk(logic [2:0] k, logic [1:0] med, logic [1:0] dest,
                                  logic [9:0] rnd, logic [3:0] flags);
    in_item_t it;
    it.kind         = k;
    it.medium_state = med;
    it.dest_group   = dest;
    it.random_value = rnd;
    {it.rx_fcs_ok, it.rx_is_ack, it.rx_broadcast, it.rx_for_us} = flags;
    return it;
  endfunction

  // Next item, steered by the tracked state so exchanges run to completion
  function automatic in_item_t pick_item();
    in_item_t    it;
    int unsigned roll;
    int unsigned pick_med;
    it   = $bits(in_item_t)'($urandom);
    roll = $urandom_range(99);
    if (roll < 6) begin
      it.kind = 3'($urandom_range(7));
    end else begin
      case (sb.state)
        MS_IDLE:
          it.kind = roll < 50 ? KIND_OFFER : roll < 75 ? KIND_MEDIUM :
                    roll < 90 ? KIND_TICK : KIND_RX;
        MS_DEFER:
          it.kind = roll < 55 ? KIND_MEDIUM : roll < 88 ? KIND_TICK : KIND_OFFER;
        MS_WAITDIFS, MS_BACKOFF:
          it.kind = roll < 89 ? KIND_TICK : roll < 96 ? KIND_MEDIUM : KIND_OFFER;
        MS_TRANSMIT:
          it.kind = roll < 78 ? KIND_TX_DONE : roll < 92 ? KIND_TICK : KIND_MEDIUM;
        MS_WAITACK:
          it.kind = roll < 80 ? KIND_TICK : KIND_RX;
        MS_RECEIVE:
          it.kind = roll < 58 ? KIND_RX : roll < 82 ? KIND_MEDIUM :
                    roll < 91 ? KIND_TICK : KIND_OFFER;
        default:
          it.kind = roll < 86 ? KIND_TICK : roll < 93 ? KIND_RX : KIND_OFFER;
      endcase
    end
    // Medium: half idle, the rest busy, receiving or the alternate busy code
    pick_med = $urandom_range(9);
    it.medium_state = pick_med < 5 ? MED_IDLE : pick_med < 7 ? MED_BUSY :
                      pick_med < 9 ? MED_RECEIVING : MED_BUSY_ALT;
    if ($urandom_range(9) < 6) it.dest_group = DEST_UNICAST;
    // Mostly well-formed acks while waiting, mostly clean frames otherwise
    if (sb.state == MS_WAITACK && $urandom_range(9) < 7) begin
      it.rx_fcs_ok = 1'b1;
      it.rx_is_ack = 1'b1;
      it.rx_for_us = 1'b1;
    end else if ($urandom_range(9) < 8) begin
      it.rx_fcs_ok = 1'b1;
    end
    return it;
  endfunction

  // Register setting for each random phase; later phases are random and compact
  function automatic cfg_t phase_config(int unsigned idx);
    cfg_t c;
    case (idx)
      0: c = '{1'b1, 16'd1, 16'd2, 16'd2, 16'd4, 10'd3, 10'd15, 4'd2};
      1: c = '{1'b0, 16'd2, 16'd1, 16'd3, 16'd3, 10'd7, 10'd7, 4'd1};
      2: c = '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd0, 10'd0, 4'd0};
      3: c = '{1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 10'd0, 10'd0, 4'd0};
      4: c = '{1'b1, 16'd0, 16'd1, 16'd1, 16'd1, 10'd1023, 10'd1023, 4'd15};
      5: c = '{1'b1, 16'd1, 16'd1, 16'd2, 16'd3, 10'd12, 10'd5, 4'd3};
      6: c = '{RST_USE_ACK, RST_SLOT_TICKS, RST_SIFS_TICKS, RST_DIFS_TICKS,
               RST_ACK_TICKS, RST_CW_MIN, RST_CW_MAX, RST_RETRY_LIMIT};
      default: begin
        c.use_ack           = 1'($urandom);
        c.slot_ticks        = 16'($urandom_range(3));
        c.sifs_ticks        = 16'($urandom_range(4));
        c.difs_ticks        = 16'($urandom_range(5));
        c.ack_timeout_ticks = 16'($urandom_range(8, 1));
        c.cw_min            = 10'($urandom_range(15));
        c.cw_max            = 10'($urandom_range(63));
        c.retry_limit       = 4'($urandom_range(4));
      end
    endcase
    return c;
  endfunction

  // Short directed walk: access, retry, give-up, receive paths, odd events
  task automatic run_directed();
    in_item_t steps[$];
    steps = '{
      mk(KIND_TICK, MED_IDLE, DEST_UNICAST, 10'd0, RX_NONE),
      mk(KIND_RESERVED, MED_RECEIVING, DEST_BROADCAST_ALT, 10'h3FF, RX_ALL),
      mk(KIND_RX, MED_IDLE, DEST_UNICAST, 10'd0, RX_ALL),
      mk(KIND_TX_DONE, MED_IDLE, DEST_UNICAST, 10'd0, RX_NONE),
      mk(KIND_MEDIUM, MED_BUSY_ALT, DEST_UNICAST, 10'd0, RX_NONE),
      mk(KIND_OFFER, MED_IDLE, DEST_UNICAST, 10'h3FF, RX_NONE),
      mk(KIND_OFFER, MED_IDLE, DEST_MULTICAST, 10'h3FF, RX_NONE),
      mk(KIND_MEDIUM, MED_IDLE, DEST_UNICAST, 10'd0, RX_NONE),
      mk(KIND_TICK, MED_IDLE, DEST_UNICAST, 10'h3FF, RX_NONE),
      mk(KIND_TICK, MED_IDLE, DEST_UNICAST, 10'h3FF, RX_NONE),
      mk(KIND_TX_DONE, MED_IDLE, DEST_UNICAST, 10'd0, RX_NONE),
      mk(KIND_TICK, MED_IDLE, DEST_UNICAST, 10'd0, RX_NONE),
      mk(KIND_TICK, MED_IDLE, DEST_UNICAST, 10'd0, RX_NONE),
      mk(KIND_TICK, MED_IDLE, DEST_UNICAST, 10'd0, RX_NONE),
      mk(KIND_TICK, MED_IDLE, DEST_UNICAST, 10'd0, RX_NONE),
      mk(KIND_TX_DONE, MED_IDLE, DEST_UNICAST, 10'd0, RX_NONE),
      mk(KIND_RX, MED_IDLE, DEST_UNICAST, 10'd0, RX_OK | RX_US),
      mk(KIND_TICK, MED_IDLE, DEST_UNICAST, 10'd0, RX_NONE),
      mk(KIND_TICK, MED_IDLE, DEST_UNICAST, 10'd0, RX_NONE),
      mk(KIND_MEDIUM, MED_RECEIVING, DEST_UNICAST, 10'd0, RX_NONE),
      mk(KIND_RX, MED_IDLE, DEST_UNICAST, 10'd0, RX_OK | RX_US),
      mk(KIND_TICK, MED_IDLE, DEST_UNICAST, 10'd0, RX_NONE),
      mk(KIND_RX, MED_IDLE, DEST_UNICAST, 10'd0, RX_US),
      mk(KIND_RX, MED_IDLE, DEST_UNICAST, 10'd0, RX_OK | RX_ACK | RX_US),
      mk(KIND_RX, MED_IDLE, DEST_UNICAST, 10'd0, RX_OK | RX_BCAST),
      mk(KIND_RX, MED_IDLE, DEST_UNICAST, 10'd0, RX_OK),
      mk(KIND_OFFER, MED_IDLE, DEST_BROADCAST_ALT, 10'd512, RX_NONE),
      mk(KIND_MEDIUM, MED_BUSY, DEST_BROADCAST, 10'd0, RX_NONE),
      mk(KIND_RX, MED_IDLE, DEST_UNICAST, 10'd0, RX_OK)
    };
    foreach (steps[i]) send_item(steps[i]);
  endtask

  // Main sequence
  initial begin
    int unsigned phase_idx;
    int unsigned n_items;
    int unsigned stall_choice[4];
    stall_choice = '{0, 15, 40, 70};
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.payload  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    stall_pct = 30;
    write_config('{1'b1, 16'd0, 16'd0, 16'd1, 16'd2, 10'd1, 10'd3, 4'd1});
    run_directed();
    drain();

    phase_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      write_config(phase_config(phase_idx));
      gaps_on   = (phase_idx % 3) != 2;
      stall_pct = stall_choice[phase_idx % 4];
      // First phase: long result hold while items keep coming, to fill the block
      if (phase_idx == 0) begin
        gaps_on  = 1'b0;
        hold_req = 1'b1;
      end
      n_items = (phase_idx == 2 || phase_idx == 4 || phase_idx == 6) ? 80 : 170;
      repeat (n_items) send_item(pick_item());
      drain();
      phase_idx++;
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
